>>> rtl/mhpq_pkg.sv
// shared types, constants and helper functions for the min-heap priority queue
package mhpq_pkg;

    // heap storage geometry
    localparam int HEAP_DEPTH = 64;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int CHILD_W    = CNT_W + 1;
    localparam int ENTRY_W    = 32;

    // fixed field widths
    localparam int KEY_W = 16;
    localparam int CAP_W = 7;
    localparam int OCC_W = 7;
    localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HEAP_DEPTH);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_REMOVED  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] time_key;
        logic [KEY_W-1:0] entry_id;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] out_time;
        logic [KEY_W-1:0] out_id;
        logic [OCC_W-1:0] occupancy;
    } rsp_t;

    // parent slot of a non-root heap position
    function automatic logic [ADDR_W-1:0] parent_of(input logic [ADDR_W-1:0] pos);
        logic [ADDR_W-1:0] dec;
        dec = pos - ADDR_W'(1);
        return dec >> 1;
    endfunction

    // left child index, wide enough to compare against the entry count
    function automatic logic [CHILD_W-1:0] left_of(input logic [ADDR_W-1:0] pos);
        return CHILD_W'({pos, 1'b1});
    endfunction

endpackage

>>> rtl/min_heap_priority_queue.sv
// Binary min-heap priority queue: entries ordered by time key, then by identifier.
// One request is handled at a time; req_stall stays high from acceptance until the
// result has been loaded into the output register, which can then hold it while the
// next request is taken. The heap lives in a 64-entry RAM with one write port and
// one registered read port, and a single 32-bit comparator walks it one heap level
// at a time. An insert sifts the new entry up, one parent compared per level; a remove
// reads the root, then the last entry, then compares the left and, if present, the right
// child on each level down, with a final write when the element lands in a slot without
// children. Refused inserts and removes from an empty queue go straight to the result.
// A result that finds the output register still stalled waits until it drains.
// No clearing pass is needed after reset: only slots below the entry count are read.
module min_heap_priority_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  mhpq_pkg::req_t             req,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output mhpq_pkg::rsp_t             rsp,
    input  logic                       cfg_we,
    input  logic [mhpq_pkg::CAP_W-1:0] cfg_data
);

    import mhpq_pkg::*;

    // sequencer state codes
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP_CMP  = 3'd1;
    localparam logic [2:0] S_RM_ROOT = 3'd2;
    localparam logic [2:0] S_RM_LAST = 3'd3;
    localparam logic [2:0] S_DN_L    = 3'd4;
    localparam logic [2:0] S_DN_R    = 3'd5;
    localparam logic [2:0] S_WR_ELEM = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [ADDR_W-1:0]  pos_reg, pos_next;
    logic [ENTRY_W-1:0] elem_reg, elem_next;
    logic [ENTRY_W-1:0] best_val_reg, best_val_next;
    logic [ADDR_W-1:0]  best_idx_reg, best_idx_next;
    logic               best_child_reg, best_child_next;
    rsp_t               res_reg, res_next;
    rsp_t               rsp_reg, rsp_next;

    // ram port signals
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // shared comparator
    logic [ENTRY_W-1:0] cmp_a, cmp_b;
    logic               cmp_lt;

    // sift-down settle step
    logic               settle;
    logic               do_move;
    logic [ENTRY_W-1:0] move_val;
    logic [ADDR_W-1:0]  move_idx;
    logic [CHILD_W-1:0] next_left;

    logic [CHILD_W-1:0] left_c, right_c, cnt_ext;
    logic [ADDR_W-1:0]  pos_parent;
    logic               heap_full;

    mhpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HEAP_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // index arithmetic around the current position
    assign left_c     = left_of(pos_reg);
    assign right_c    = left_c + CHILD_W'(1);
    assign cnt_ext    = CHILD_W'(count_reg);
    assign pos_parent = parent_of(pos_reg);
    assign heap_full  = (CMP_W'(count_reg) >= CMP_W'(cap_reg)) || (count_reg >= DEPTH_CNT);

    // the one compare unit: strict less-than on packed {time, id}
    assign cmp_lt = cmp_a < cmp_b;

    // configuration register
    assign cap_next = cfg_we ? cfg_data : cap_reg;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rsp_valid_next  = rsp_valid_reg;
        pos_next        = pos_reg;
        elem_next       = elem_reg;
        best_val_next   = best_val_reg;
        best_idx_next   = best_idx_reg;
        best_child_next = best_child_reg;
        res_next        = res_reg;
        rsp_next        = rsp_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = elem_reg;
        ram_raddr       = '0;
        cmp_a           = ram_rdata;
        cmp_b           = elem_reg;
        settle          = 1'b0;
        do_move         = 1'b0;
        move_val        = ram_rdata;
        move_idx        = left_c[ADDR_W-1:0];

        // output register drains on a completed transaction
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_next = '0;
                    if (req.req_type == REQ_INSERT)
                    begin
                        if (heap_full)
                        begin
                            res_next.status = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            res_next.status = ST_INSERTED;
                            elem_next       = {req.time_key, req.entry_id};
                            pos_next        = count_reg[ADDR_W-1:0];
                            count_next      = count_reg + CNT_W'(1);
                            if (count_reg == '0)
                            begin
                                state_next = S_WR_ELEM;
                            end
                            else
                            begin
                                ram_raddr  = parent_of(count_reg[ADDR_W-1:0]);
                                state_next = S_UP_CMP;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            res_next.status = ST_REMOVED;
                            ram_raddr       = '0;
                            state_next      = S_RM_ROOT;
                        end
                    end
                end
            end

            // sift up: move the parent down while the new entry ranks before it
            S_UP_CMP:
            begin
                cmp_a = elem_reg;
                cmp_b = ram_rdata;
                ram_we = 1'b1;
                if (cmp_lt)
                begin
                    ram_wdata = ram_rdata;
                    pos_next  = pos_parent;
                    if (pos_parent == '0)
                    begin
                        state_next = S_WR_ELEM;
                    end
                    else
                    begin
                        ram_raddr = parent_of(pos_parent);
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // root comes back, fetch the last entry
            S_RM_ROOT:
            begin
                res_next.out_time = ram_rdata[ENTRY_W-1:KEY_W];
                res_next.out_id   = ram_rdata[KEY_W-1:0];
                count_next        = count_reg - CNT_W'(1);
                ram_raddr         = ADDR_W'(count_reg - CNT_W'(1));
                state_next        = S_RM_LAST;
            end

            // last entry becomes the element to sink from the root
            S_RM_LAST:
            begin
                elem_next = ram_rdata;
                pos_next  = '0;
                if (count_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (count_reg > CNT_W'(1))
                begin
                    ram_raddr  = ADDR_W'(1);
                    state_next = S_DN_L;
                end
                else
                begin
                    state_next = S_WR_ELEM;
                end
            end

            // left child against the sinking element
            S_DN_L:
            begin
                cmp_a           = ram_rdata;
                cmp_b           = elem_reg;
                best_val_next   = cmp_lt ? ram_rdata : elem_reg;
                best_child_next = cmp_lt;
                best_idx_next   = left_c[ADDR_W-1:0];
                if (right_c < cnt_ext)
                begin
                    ram_raddr  = right_c[ADDR_W-1:0];
                    state_next = S_DN_R;
                end
                else
                begin
                    settle   = 1'b1;
                    do_move  = cmp_lt;
                    move_val = ram_rdata;
                    move_idx = left_c[ADDR_W-1:0];
                end
            end

            // right child against the best so far
            S_DN_R:
            begin
                cmp_a  = ram_rdata;
                cmp_b  = best_val_reg;
                settle = 1'b1;
                if (cmp_lt)
                begin
                    do_move  = 1'b1;
                    move_val = ram_rdata;
                    move_idx = right_c[ADDR_W-1:0];
                end
                else
                begin
                    do_move  = best_child_reg;
                    move_val = best_val_reg;
                    move_idx = best_idx_reg;
                end
            end

            S_WR_ELEM:
            begin
                ram_we     = 1'b1;
                state_next = S_DONE;
            end

            // hand the result to the output register once it is free
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next           = res_reg;
                    rsp_next.occupancy = OCC_W'(count_reg);
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // sift-down step: lift the winning child or park the element
        next_left = left_of(move_idx);
        if (settle)
        begin
            ram_we = 1'b1;
            if (do_move)
            begin
                ram_wdata = move_val;
                pos_next  = move_idx;
                if (next_left < cnt_ext)
                begin
                    ram_raddr  = next_left[ADDR_W-1:0];
                    state_next = S_DN_L;
                end
                else
                begin
                    state_next = S_WR_ELEM;
                end
            end
            else
            begin
                state_next = S_DONE;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        elem_reg       <= elem_next;
        best_val_reg   <= best_val_next;
        best_idx_reg   <= best_idx_next;
        best_child_reg <= best_child_next;
        res_reg        <= res_next;
        rsp_reg        <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> rtl/mhpq_ram.sv
// generic single write port, single read port ram with registered read data
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/mhpq_checker.sv
// port-level checks for the min-heap priority queue, bound to the top level
module mhpq_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input mhpq_pkg::rsp_t rsp
);

    import mhpq_pkg::*;

    // a stalled result transaction holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // one request in flight: accepting a request makes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request port not stalled after acceptance");

    // occupancy never exceeds the heap depth
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.occupancy <= OCC_W'(HEAP_DEPTH))
        else $error("occupancy above heap depth");

    // refused and empty results carry no entry
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_EMPTY)
            |-> rsp.out_time == '0 && rsp.out_id == '0)
        else $error("refused or empty result carries data");

    // an empty queue reports zero occupancy, an insert leaves at least one entry
    a_occ_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status != ST_EMPTY || rsp.occupancy == '0)
            && (rsp.status != ST_INSERTED || rsp.occupancy != '0))
        else $error("occupancy inconsistent with status");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (.*);
